// File: rtl/core/ecma_pkg.sv
// Shared types and codes for the element conductivity matrix accumulator.
`default_nettype none

package ecma_pkg;

   localparam int DATA_W = 32;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_ACCUM = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_COND_XX   = 2'd0,
      CSR_COND_XY   = 2'd1,
      CSR_COND_YY   = 2'd2,
      CSR_DOF_COUNT = 2'd3
   } csr_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_ADD = 1'b1
   } op_type;

   // Micro-operations of one matrix entry, in issue order.
   typedef enum logic [3:0] {
      UOP_XX  = 4'd0,
      UOP_YXY = 4'd1,
      UOP_T1  = 4'd2,
      UOP_XXY = 4'd3,
      UOP_YYY = 4'd4,
      UOP_T2  = 4'd5,
      UOP_IX  = 4'd6,
      UOP_IY  = 4'd7,
      UOP_S   = 4'd8,
      UOP_W   = 4'd9,
      UOP_ACC = 4'd10
   } uop_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] cond_xx;
      logic signed [DATA_W-1:0] cond_xy;
      logic signed [DATA_W-1:0] cond_yy;
      logic [4:0]               dof_count;
   } cfg_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     clip;
   } unit_rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/element_conductivity_matrix_accumulate.sv
// Top level: configuration registers, stream packing, sequencer and shared unit.
//
//   channel | dir | handshake            | contents
//   req     | in  | req_tvalid/tready    | tuser command; tdata row, col, grad_x, grad_y, weight
//   rsp     | out | rsp_tvalid/tready    | tdata entry_value; tuser saturated, bad_index
//   csr     | in  | csr_we               | csr_index selects register, csr_wdata value
//
// Load and read pass from accept through the finish state to the result register.
// Clear sweeps all 2^(2*clog2(MAX_DOF)) words of the matrix memory (256 at
// MAX_DOF 16). Accumulate walks the n*(n+1)/2 upper-triangle entries for n
// degrees of freedom: each is a memory read, then 11 operations through the
// single multiply/add unit. Reset clears control and loads config defaults;
// matrix contents are undefined until the first clear. A result waits in an
// output register; the next item is taken once the sequencer is idle again.
`default_nettype none

module element_conductivity_matrix_accumulate #(
   parameter int MAX_DOF = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // [3:0] row_index, [7:4] col_index, [39:8] grad_x, [71:40] grad_y, [103:72] weight
   input  wire logic [103:0] req_tdata,
   // [1:0] command
   input  wire logic [1:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] entry_value
   output      logic [31:0]  rsp_tdata,
   // [0] saturated, [1] bad_index
   output      logic [1:0]   rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   import ecma_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   unit_req_type       unit_req;
   unit_rsp_type       unit_rsp;
   logic signed [31:0] entry_value;
   logic               saturated;
   logic               bad_index;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_COND_XX:   cfg_in.cond_xx   = csr_wdata;
            CSR_COND_XY:   cfg_in.cond_xy   = csr_wdata;
            CSR_COND_YY:   cfg_in.cond_yy   = csr_wdata;
            CSR_DOF_COUNT: cfg_in.dof_count = csr_wdata[4:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cond_xx   <= '0;
         cfg_ff.cond_xy   <= '0;
         cfg_ff.cond_yy   <= '0;
         cfg_ff.dof_count <= 5'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ecma_seq #(
      .MAX_DOF (MAX_DOF)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_command     (cmd_type'(req_tuser)),
      .req_row         (req_tdata[3:0]),
      .req_col         (req_tdata[7:4]),
      .req_grad_x      (req_tdata[39:8]),
      .req_grad_y      (req_tdata[71:40]),
      .req_weight      (req_tdata[103:72]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_entry_value (entry_value),
      .rsp_saturated   (saturated),
      .rsp_bad_index   (bad_index),
      .unit_req        (unit_req),
      .unit_rsp        (unit_rsp)
   );

   ecma_unit u_unit (
      .clock    (clock),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   assign rsp_tdata = entry_value;
   assign rsp_tuser = {bad_index, saturated};

endmodule

`default_nettype wire

// File: rtl/core/ecma_unit.sv
// Shared Q16.16 multiply/add unit with floor shift and 32-bit saturation.
`default_nettype none

module ecma_unit (
   input  wire logic                  clock,
   input  wire ecma_pkg::unit_req_type unit_req,
   output      ecma_pkg::unit_rsp_type unit_rsp
);
   import ecma_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [32:0] sum;
   logic [16:0]        head;
   logic               ovf;

   // A sum is placed 16 bits up so both paths share the shift and clip.
   always_comb begin
      sum = {unit_req.a[DATA_W-1], unit_req.a} + {unit_req.b[DATA_W-1], unit_req.b};
      if (unit_req.op == OP_MUL) begin
         prod_in = unit_req.a * unit_req.b;
      end else begin
         prod_in = {{15{sum[32]}}, sum, 16'b0};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Arithmetic shift by 16 floors; clip when bits 63 down to 47 disagree.
   always_comb begin
      head           = prod_ff[63:47];
      ovf            = !((&head) || (~|head));
      unit_rsp.clip  = ovf;
      if (ovf) begin
         unit_rsp.value = prod_ff[63] ? Q_MIN : Q_MAX;
      end else begin
         unit_rsp.value = prod_ff[47:16];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ecma_seq.sv
// Command sequencer with derivative and matrix memories and the result register.
`default_nettype none

module ecma_seq #(
   parameter int MAX_DOF = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ecma_pkg::cfg_type      cfg,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire ecma_pkg::cmd_type      req_command,
   input  wire logic [3:0]             req_row,
   input  wire logic [3:0]             req_col,
   input  wire logic signed [31:0]     req_grad_x,
   input  wire logic signed [31:0]     req_grad_y,
   input  wire logic signed [31:0]     req_weight,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic signed [31:0]     rsp_entry_value,
   output      logic                   rsp_saturated,
   output      logic                   rsp_bad_index,
   output      ecma_pkg::unit_req_type unit_req,
   input  wire ecma_pkg::unit_rsp_type unit_rsp
);
   import ecma_pkg::*;

   localparam int IW     = $clog2(MAX_DOF);
   localparam int NW     = $clog2(MAX_DOF + 1);
   localparam int KW     = (NW > 4) ? NW : 4;
   localparam int CW     = NW + 1;
   localparam int AW     = 2 * IW;
   localparam int MDEPTH = 1 << AW;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_CLEAR     = 8'b0000_0010,
      ST_ROW_RD    = 8'b0000_0100,
      ST_ROW_LATCH = 8'b0000_1000,
      ST_COL_RD    = 8'b0001_0000,
      ST_ISSUE     = 8'b0010_0000,
      ST_CAPT      = 8'b0100_0000,
      ST_FINISH    = 8'b1000_0000
   } state_type;

   // Memories
   logic signed [31:0] dx_mem [MAX_DOF];
   logic signed [31:0] dy_mem [MAX_DOF];
   logic signed [31:0] mat_mem [MDEPTH];

   // Control registers
   state_type       state_ff, state_in;
   logic [IW-1:0]   i_ff, i_in;
   logic [IW-1:0]   j_ff, j_in;
   uop_type         step_ff, step_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            sat_ff, sat_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Payload registers
   cmd_type            cmd_ff, cmd_in;
   logic               bad_ff, bad_in;
   logic signed [31:0] w_ff, w_in;
   logic signed [31:0] dxi_ff, dxi_in;
   logic signed [31:0] dyi_ff, dyi_in;
   logic signed [31:0] r0_ff, r0_in;
   logic signed [31:0] r1_ff, r1_in;
   logic signed [31:0] t1_ff, t1_in;
   logic signed [31:0] t2_ff, t2_in;
   logic signed [31:0] dxq_ff, dyq_ff, matq_ff;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_sat_ff, rsp_sat_in;
   logic               rsp_bad_ff, rsp_bad_in;

   // Memory port controls
   logic               d_we;
   logic [IW-1:0]      d_waddr;
   logic               d_re;
   logic [IW-1:0]      d_raddr;
   logic               mat_we;
   logic [AW-1:0]      mat_waddr;
   logic signed [31:0] mat_wdata;
   logic               mat_re;
   logic [AW-1:0]      mat_raddr;

   logic [NW-1:0]      n_cnt;
   logic               req_accept;
   logic               out_free;
   logic               row_ok;
   logic               col_ok;
   logic [CW-1:0]      j_next;
   logic [CW-1:0]      i_next;

   always_comb begin
      if (32'(cfg.dof_count) >= MAX_DOF) begin
         n_cnt = NW'(MAX_DOF);
      end else begin
         n_cnt = NW'(cfg.dof_count);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign row_ok     = KW'(req_row) < KW'(n_cnt);
   assign col_ok     = KW'(req_col) < KW'(n_cnt);
   assign j_next     = CW'(j_ff) + CW'(1);
   assign i_next     = CW'(i_ff) + CW'(1);

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_saturated   = rsp_sat_ff;
   assign rsp_bad_index   = rsp_bad_ff;

   // Operand select for the shared unit
   always_comb begin
      unit_req.op = OP_MUL;
      unit_req.a  = dxq_ff;
      unit_req.b  = cfg.cond_xx;
      case (step_ff)
         UOP_XX: begin
            unit_req.a = dxq_ff;
            unit_req.b = cfg.cond_xx;
         end
         UOP_YXY: begin
            unit_req.a = dyq_ff;
            unit_req.b = cfg.cond_xy;
         end
         UOP_XXY: begin
            unit_req.a = dxq_ff;
            unit_req.b = cfg.cond_xy;
         end
         UOP_YYY: begin
            unit_req.a = dyq_ff;
            unit_req.b = cfg.cond_yy;
         end
         UOP_IX: begin
            unit_req.a = t1_ff;
            unit_req.b = dxi_ff;
         end
         UOP_IY: begin
            unit_req.a = t2_ff;
            unit_req.b = dyi_ff;
         end
         UOP_W: begin
            unit_req.a = t1_ff;
            unit_req.b = w_ff;
         end
         UOP_T1, UOP_T2, UOP_S: begin
            unit_req.op = OP_ADD;
            unit_req.a  = r0_ff;
            unit_req.b  = r1_ff;
         end
         UOP_ACC: begin
            unit_req.op = OP_ADD;
            unit_req.a  = matq_ff;
            unit_req.b  = r0_ff;
         end
         default: begin
            unit_req.op = OP_MUL;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      cmd_in       = cmd_ff;
      bad_in       = bad_ff;
      w_in         = w_ff;
      dxi_in       = dxi_ff;
      dyi_in       = dyi_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_bad_in   = rsp_bad_ff;

      d_we      = 1'b0;
      d_waddr   = IW'(req_row);
      d_re      = 1'b0;
      d_raddr   = j_ff;
      mat_we    = 1'b0;
      mat_waddr = {i_ff, j_ff};
      mat_wdata = unit_rsp.value;
      mat_re    = 1'b0;
      mat_raddr = {i_ff, j_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in = req_command;
               bad_in = 1'b0;
               w_in   = req_weight;
               unique case (req_command)
                  CMD_CLEAR: begin
                     sat_in   = 1'b0;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_LOAD: begin
                     d_we     = row_ok;
                     bad_in   = !row_ok;
                     state_in = ST_FINISH;
                  end
                  CMD_ACCUM: begin
                     i_in = '0;
                     j_in = '0;
                     if (n_cnt == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_ROW_RD;
                     end
                  end
                  CMD_READ: begin
                     bad_in    = !row_ok || !col_ok || (req_row > req_col);
                     mat_re    = 1'b1;
                     mat_raddr = {IW'(req_row), IW'(req_col)};
                     state_in  = ST_FINISH;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            mat_we    = 1'b1;
            mat_waddr = clr_ff;
            mat_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_FINISH;
            end
         end
         ST_ROW_RD: begin
            d_re     = 1'b1;
            d_raddr  = i_ff;
            state_in = ST_ROW_LATCH;
         end
         ST_ROW_LATCH: begin
            // Hold the row node and fetch the column node (same node first).
            dxi_in   = dxq_ff;
            dyi_in   = dyq_ff;
            d_re     = 1'b1;
            mat_re   = 1'b1;
            step_in  = UOP_XX;
            state_in = ST_ISSUE;
         end
         ST_COL_RD: begin
            d_re     = 1'b1;
            mat_re   = 1'b1;
            step_in  = UOP_XX;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_CAPT;
         end
         ST_CAPT: begin
            sat_in = sat_ff | unit_rsp.clip;
            case (step_ff)
               UOP_XX, UOP_XXY, UOP_IX, UOP_W: r0_in = unit_rsp.value;
               UOP_YXY, UOP_YYY, UOP_IY:       r1_in = unit_rsp.value;
               UOP_T1, UOP_S:                  t1_in = unit_rsp.value;
               UOP_T2:                         t2_in = unit_rsp.value;
               default:                        mat_we = 1'b1;
            endcase
            if (step_ff == UOP_ACC) begin
               if (j_next < CW'(n_cnt)) begin
                  j_in     = j_next[IW-1:0];
                  state_in = ST_COL_RD;
               end else if (i_next < CW'(n_cnt)) begin
                  i_in     = i_next[IW-1:0];
                  j_in     = i_next[IW-1:0];
                  state_in = ST_ROW_RD;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               step_in  = uop_type'(step_ff + 4'd1);
               state_in = ST_ISSUE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = sat_ff;
               rsp_bad_in   = bad_ff;
               if (cmd_ff == CMD_READ && !bad_ff) begin
                  rsp_value_in = matq_ff;
               end else begin
                  rsp_value_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         step_ff      <= UOP_XX;
         clr_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      bad_ff       <= bad_in;
      w_ff         <= w_in;
      dxi_ff       <= dxi_in;
      dyi_ff       <= dyi_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         dx_mem[d_waddr] <= req_grad_x;
         dy_mem[d_waddr] <= req_grad_y;
      end
      if (d_re) begin
         dxq_ff <= dx_mem[d_raddr];
         dyq_ff <= dy_mem[d_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_waddr] <= mat_wdata;
      end
      if (mat_re) begin
         matq_ff <= mat_mem[mat_raddr];
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after taking an item");

   a_upper_triangle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (i_ff <= j_ff))
      else $error("entry below the diagonal in accumulate walk");

   a_mat_write_src: assert property (@(posedge clock) disable iff (reset)
      mat_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_CAPT && step_ff == UOP_ACC)))
      else $error("matrix written outside clear or accumulate");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished item not placed in result register");

   a_clear_sat: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == CMD_CLEAR) |=> !sat_ff)
      else $error("saturation flag survived a clear");

endmodule

`default_nettype wire
